[design/pipc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and helpers for the point-in-polygon crossing unit
// Coordinate width, channel payloads, edge records and the edge classifier.
// ----------------------------------------------------------------------------
package pipc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int PROD_W     = 2 * COORD_BITS + 2;
  localparam int DIFF_W     = PROD_W + 1;

  localparam logic [1:0] EK_NONE  = 2'd0;
  localparam logic [1:0] EK_HIT   = 2'd1;
  localparam logic [1:0] EK_CROSS = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic                      first_vertex;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic inside_or_on;
    logic on_contour;
  } out_item_t;

  // classified edge, y rising, before the products are formed
  typedef struct packed {
    logic [1:0] kind;
    delta_t     dy;
    delta_t     dx;
    delta_t     ex;
    delta_t     ey;
  } edge_op_t;

  // edge with its two cross-product terms
  typedef struct packed {
    logic [1:0] kind;
    prod_t      p1;
    prod_t      p2;
  } edge_res_t;

  typedef struct packed {
    logic      first;
    logic      last;
    edge_res_t e0;
    edge_res_t e1;
  } q_entry_t;

  typedef struct packed {
    logic          valid;
    logic [Q_AW:0] count;
  } q_stat_t;

  function automatic coord_t to_coord(logic [FIELD_W-1:0] f);
    logic [COORD_BITS-1:0] t;
    t = COORD_BITS'(f);
    return $signed(t);
  endfunction

  function automatic edge_op_t classify(coord_t px, coord_t py, coord_t ax, coord_t ay,
                                        coord_t bx, coord_t by);
    edge_op_t r;
    delta_t   dy_raw;
    coord_t   lx;
    coord_t   ly;
    coord_t   hy;
    r      = '0;
    r.kind = EK_NONE;
    dy_raw = delta_t'(by) - delta_t'(ay);
    if (dy_raw == '0) begin
      if (py == ay && ((bx <= px && px <= ax) || (ax <= px && px <= bx))) begin
        r.kind = EK_HIT;
      end
    end else begin
      // orient so that y rises
      if (dy_raw < 0) begin
        lx   = bx;
        ly   = by;
        hy   = ay;
        r.dx = delta_t'(ax) - delta_t'(bx);
        r.dy = -dy_raw;
      end else begin
        lx   = ax;
        ly   = ay;
        hy   = by;
        r.dx = delta_t'(bx) - delta_t'(ax);
        r.dy = dy_raw;
      end
      r.ex = delta_t'(px) - delta_t'(lx);
      r.ey = delta_t'(py) - delta_t'(ly);
      if (py < ly || py > hy) begin
        r.kind = EK_NONE;
      end else if (py == ly) begin
        r.kind = (px == lx) ? EK_HIT : EK_NONE;
      end else begin
        r.kind = EK_CROSS;
      end
    end
    return r;
  endfunction

endpackage

[design/pipc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_front: vertex intake and edge classification
// Tracks start and previous vertex, classifies the incoming and closing edge,
// forms the cross-product terms and pushes one record per vertex.
// ----------------------------------------------------------------------------
module pipc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pipc_pkg::in_item_t  in_data,
  input  pipc_pkg::q_stat_t   q_stat,
  output logic                push,
  output pipc_pkg::q_entry_t  push_data
);
  import pipc_pkg::*;

  coord_t   start_x_r, start_y_r, prev_x_r, prev_y_r;
  coord_t   px, py, vx, vy, cx, cy;
  logic     f_valid_r, f_valid_nxt;
  logic     f_first_r, f_last_r;
  edge_op_t f_e0_r, f_e1_r;
  edge_op_t e0, e1;
  logic     acc;
  logic [Q_AW:0] credit_used;

  // reserve a queue slot for the record still in the stage register
  assign credit_used = q_stat.count + (Q_AW+1)'(f_valid_r);
  assign in_stall    = credit_used >= (Q_AW+1)'(Q_DEPTH);
  assign acc         = in_valid && !in_stall;

  always_comb begin
    px = to_coord(in_data.point_x);
    py = to_coord(in_data.point_y);
    vx = to_coord(in_data.vertex_x);
    vy = to_coord(in_data.vertex_y);
    cx = in_data.first_vertex ? vx : start_x_r;
    cy = in_data.first_vertex ? vy : start_y_r;
    e0 = classify(px, py, prev_x_r, prev_y_r, vx, vy);
    e1 = classify(px, py, vx, vy, cx, cy);
    if (in_data.first_vertex) e0.kind = EK_NONE;
    if (!in_data.last_vertex) e1.kind = EK_NONE;
  end

  assign f_valid_nxt = acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (in_data.first_vertex) begin
        start_x_r <= vx;
        start_y_r <= vy;
      end
      prev_x_r  <= vx;
      prev_y_r  <= vy;
      f_first_r <= in_data.first_vertex;
      f_last_r  <= in_data.last_vertex;
      f_e0_r    <= e0;
      f_e1_r    <= e1;
    end
  end

  // products land in the queue register
  always_comb begin
    push_data.first   = f_first_r;
    push_data.last    = f_last_r;
    push_data.e0.kind = f_e0_r.kind;
    push_data.e0.p1   = prod_t'(f_e0_r.dy) * prod_t'(f_e0_r.ex);
    push_data.e0.p2   = prod_t'(f_e0_r.dx) * prod_t'(f_e0_r.ey);
    push_data.e1.kind = f_e1_r.kind;
    push_data.e1.p1   = prod_t'(f_e1_r.dy) * prod_t'(f_e1_r.ex);
    push_data.e1.p2   = prod_t'(f_e1_r.dx) * prod_t'(f_e1_r.ey);
  end

  assign push = f_valid_r;

endmodule

[design/pipc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_queue: short edge-record queue
// Register FIFO between classification and accumulation.
// ----------------------------------------------------------------------------
module pipc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pipc_pkg::q_entry_t  push_data,
  input  logic                pop,
  output pipc_pkg::q_entry_t  head,
  output pipc_pkg::q_stat_t   q_stat
);
  import pipc_pkg::*;

  q_entry_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.valid = count_r != '0;
  assign q_stat.count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> count_r != (Q_AW+1)'(Q_DEPTH))
    else $error("edge queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("edge queue underflow");

endmodule

[design/pipc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipc_back: parity and contour accumulation
// Resolves cross-product signs, keeps parity and the sticky contour flag,
// and registers one result per closed polygon.
// ----------------------------------------------------------------------------
module pipc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pipc_pkg::q_stat_t   q_stat,
  input  pipc_pkg::q_entry_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pipc_pkg::out_item_t out_data
);
  import pipc_pkg::*;

  logic      par_r, par_nxt, con_r, con_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      t0, h0, t1, h1, par_new, con_new;

  function automatic logic [1:0] resolve(edge_res_t e);
    diff_t d;
    logic  tog;
    logic  hit;
    d   = diff_t'(e.p1) - diff_t'(e.p2);
    tog = 1'b0;
    hit = 1'b0;
    case (e.kind)
      EK_HIT:   hit = 1'b1;
      EK_CROSS: begin
        hit = d == '0;
        tog = d > 0;
      end
      default:  ;
    endcase
    return {tog, hit};
  endfunction

  assign pop = q_stat.valid && (!out_valid_r || !out_stall);

  always_comb begin
    {t0, h0} = resolve(head.e0);
    {t1, h1} = resolve(head.e1);
    // a first vertex starts from a clean state
    par_new  = (head.first ? 1'b0 : par_r) ^ t0 ^ t1;
    con_new  = (head.first ? 1'b0 : con_r) | h0 | h1;
    par_nxt  = par_r;
    con_nxt  = con_r;
    if (pop) begin
      par_nxt = head.last ? 1'b0 : par_new;
      con_nxt = head.last ? 1'b0 : con_new;
    end
    out_valid_nxt = (out_valid_r && out_stall) || (pop && head.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r       <= 1'b0;
      con_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      par_r       <= par_nxt;
      con_r       <= con_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data_r.inside_or_on <= par_new | con_new;
      out_data_r.on_contour   <= con_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/point_in_polygon_crossing_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_unit: streaming crossing-number polygon test
// Feeds one vertex per transfer with the test point; one result per polygon.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one vertex per transfer with
// the test point, first_vertex opening and last_vertex closing a polygon.
// Output channel (out_valid / out_stall / out_data): one transfer per closed
// polygon, carrying inside_or_on and on_contour.
// Throughput: one vertex per cycle, sustained, while the receiver keeps up.
// A result passes from its last vertex through the classify stage register, the
// edge queue and the result register before it is presented.
// The front holds in_stall high when the 4-entry edge queue plus the record
// in flight in the classify stage would fill it; this sets the throughput
// under backpressure. A stalled result holds in the output register and the
// back stops draining the queue, which then fills and raises in_stall.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and clears parity and the contour flag; start and previous vertex are
// undefined until the first vertex of a polygon is seen.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pipc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pipc_pkg::out_item_t out_data
);
  import pipc_pkg::*;

  q_stat_t  q_stat;
  q_entry_t push_data, head;
  logic     push, pop;

  pipc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  pipc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pipc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count + (Q_AW+1)'(push)) <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue credit exceeded");

  a_push_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> push)
    else $error("accepted vertex not pushed");

endmodule

[tb/sv/tb_point_in_polygon_crossing_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_crossing_unit: self-checking bench for the crossing unit
// Streams directed and random polygons through the vertex channel, predicts
// the inside and on-contour verdict of every closed polygon and compares each
// result transfer, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_crossing_unit;
  import pipc_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 357;

  typedef enum int {SC_TINY, SC_NEAR, SC_EDGE, SC_FULL} coord_scale_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // predicted polygon state
  longint    poly_start_x, poly_start_y, poly_prev_x, poly_prev_y;
  bit        crossing_parity = 1'b0;
  bit        contour_seen = 1'b0;
  bit        start_known = 1'b0;
  out_item_t pending_verdicts[$];

  point_in_polygon_crossing_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // crossing rule for one edge a -> b against point p
  function automatic void score_edge(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by);
    longint dx, dy, lx, ly, hy, cross_val;
    dx = bx - ax;
    dy = by - ay;
    if (dy != 0) begin
      if (dy < 0) begin
        lx = bx;
        ly = by;
        hy = ay;
        dx = -dx;
        dy = -dy;
      end else begin
        lx = ax;
        ly = ay;
        hy = by;
      end
      if (py < ly || py > hy) return;
      if (py == ly) begin
        if (px == lx) contour_seen = 1'b1;
        return;
      end
      cross_val = dy * (px - lx) - dx * (py - ly);
      if (cross_val == 0) contour_seen = 1'b1;
      else if (cross_val > 0) crossing_parity = ~crossing_parity;
    end else begin
      if (py != ay) return;
      if ((bx <= px && px <= ax) || (ax <= px && px <= bx)) contour_seen = 1'b1;
    end
  endfunction

  function automatic void advance_crossing_state(in_item_t it);
    longint    px, py, vx, vy;
    out_item_t verdict;
    px = longint'($signed(it.point_x));
    py = longint'($signed(it.point_y));
    vx = longint'($signed(it.vertex_x));
    vy = longint'($signed(it.vertex_y));
    if (it.first_vertex) begin
      poly_start_x    = vx;
      poly_start_y    = vy;
      crossing_parity = 1'b0;
      contour_seen    = 1'b0;
      start_known     = 1'b1;
    end else begin
      score_edge(px, py, poly_prev_x, poly_prev_y, vx, vy);
    end
    poly_prev_x = vx;
    poly_prev_y = vy;
    if (it.last_vertex) begin
      score_edge(px, py, vx, vy, poly_start_x, poly_start_y);
      verdict.inside_or_on = crossing_parity | contour_seen;
      verdict.on_contour   = contour_seen;
      pending_verdicts = {pending_verdicts, verdict};
      crossing_parity = 1'b0;
      contour_seen    = 1'b0;
    end
  endfunction

  function automatic coord_t rand_coord(coord_scale_t scale);
    int extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case (scale)
      SC_TINY: return coord_t'($urandom_range(12) - 6);
      SC_NEAR: return coord_t'($urandom_range(400) - 200);
      SC_EDGE: return coord_t'(extremes[$urandom_range(6)]);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // one vertex transfer; starts and ends at a falling edge
  task automatic send_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                             bit first, bit last);
    in_item_t it;
    it.point_x      = px;
    it.point_y      = py;
    it.vertex_x     = vx;
    it.vertex_y     = vy;
    // the stream must open with a first vertex
    it.first_vertex = first | ~start_known;
    it.last_vertex  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    advance_crossing_state(it);
    @(negedge clk);
  endtask

  task automatic test_single_vertex();
    send_vertex(5, 5, 5, 5, 1, 1);
    send_vertex(5, 6, 5, 5, 1, 1);
    send_vertex(-32768, 32767, -32768, 32767, 1, 1);
    send_vertex(32767, -32768, -32768, 32767, 1, 1);
  endtask

  task automatic test_extreme_square();
    send_vertex(0, 0, -32768, -32768, 1, 0);
    send_vertex(0, 0, 32767, -32768, 0, 0);
    send_vertex(0, 0, 32767, 32767, 0, 0);
    send_vertex(0, 0, -32768, 32767, 0, 1);
  endtask

  task automatic test_triangle_contour();
    // inside, on the slanted edge, on the horizontal edge
    send_vertex(3, 3, 0, 0, 1, 0);
    send_vertex(3, 3, 10, 0, 0, 0);
    send_vertex(3, 3, 0, 10, 0, 1);
    send_vertex(5, 5, 0, 0, 1, 0);
    send_vertex(5, 5, 10, 0, 0, 0);
    send_vertex(5, 5, 0, 10, 0, 1);
    send_vertex(4, 0, 0, 0, 1, 0);
    send_vertex(4, 0, 10, 0, 0, 0);
    send_vertex(4, 0, 0, 10, 0, 1);
  endtask

  task automatic test_continuation();
    // no first vertex: edges run on from the last closed vertex
    send_vertex(15, 10, 20, 0, 0, 0);
    send_vertex(15, 10, 20, 20, 0, 1);
  endtask

  task automatic test_point_change();
    send_vertex(2, 2, 0, 0, 1, 0);
    send_vertex(20, 20, 10, 0, 0, 0);
    send_vertex(2, 2, 0, 10, 0, 1);
  endtask

  task automatic test_restart_midway();
    send_vertex(7, 7, 100, 100, 1, 0);
    send_vertex(1, 1, 0, 0, 1, 0);
    send_vertex(1, 1, 8, 0, 0, 0);
    send_vertex(1, 1, 0, 8, 0, 1);
  endtask

  task automatic test_random_polygons(int n_items, int gap_pct, int stall_pct);
    int           sent;
    int           pick;
    int           nv;
    int           j;
    int           j2;
    coord_scale_t scale;
    coord_t       vx[16];
    coord_t       vy[16];
    coord_t       px;
    coord_t       py;
    send_idle_pct  = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick  = $urandom_range(99);
      scale = coord_scale_t'($urandom_range(3));
      if (pick < 80) begin
        nv = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        for (int k = 0; k < nv; k++) begin
          vx[k] = rand_coord(scale);
          vy[k] = rand_coord(scale);
        end
        j  = $urandom_range(nv - 1);
        j2 = (j + 1) % nv;
        case ($urandom_range(9))
          0, 1, 2: begin
            px = vx[j];
            py = vy[j];
          end
          3, 4: begin
            px = coord_t'((int'(vx[j]) + int'(vx[j2])) >>> 1);
            py = coord_t'((int'(vy[j]) + int'(vy[j2])) >>> 1);
          end
          5: begin
            px = vx[j];
            py = rand_coord(scale);
          end
          default: begin
            px = rand_coord(scale);
            py = rand_coord(scale);
          end
        endcase
        for (int k = 0; k < nv; k++) begin
          // occasionally move the point to a random spot partway through the polygon
          if ($urandom_range(19) == 0) begin
            px = rand_coord(scale);
            py = rand_coord(scale);
          end
          send_vertex(px, py, vx[k], vy[k], k == 0, k == nv - 1);
          sent++;
        end
      end else if (pick < 90) begin
        nv = $urandom_range(1, 4);
        px = rand_coord(scale);
        py = rand_coord(scale);
        for (int k = 0; k < nv; k++) begin
          send_vertex(px, py, rand_coord(scale), rand_coord(scale), 0, k == nv - 1);
          sent++;
        end
      end else begin
        send_vertex(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                    coord_t'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with none pending: inside_or_on=%0b on_contour=%0b",
               out_data.inside_or_on, out_data.on_contour);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.inside_or_on !== want.inside_or_on) begin
          $error("inside_or_on: expected %0b, got %0b", want.inside_or_on,
                 out_data.inside_or_on);
          mismatch_count++;
        end
        if (out_data.on_contour !== want.on_contour) begin
          $error("on_contour: expected %0b, got %0b", want.on_contour, out_data.on_contour);
          mismatch_count++;
        end
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[point_in_polygon_crossing_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_vertex();
    test_extreme_square();
    test_triangle_contour();
    test_continuation();
    test_point_change();
    test_restart_midway();
    test_random_polygons(PHASE_ITEMS, 0, 0);
    test_random_polygons(PHASE_ITEMS, 85, 0);
    test_random_polygons(PHASE_ITEMS, 0, 85);
    test_random_polygons(PHASE_ITEMS, 33, 33);
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[point_in_polygon_crossing_unit] OK");
    end else begin
      $display("[point_in_polygon_crossing_unit] ERROR");
    end
    $finish;
  end

endmodule
